FILE: hdl/playfield_beam_video_generator_assert.svh
// Assertion macros shared by the checker of the playfield beam video generator.
// Depends on nothing; include it by its bare file name.
`ifndef PLAYFIELD_BEAM_VIDEO_GENERATOR_ASSERT_SVH
`define PLAYFIELD_BEAM_VIDEO_GENERATOR_ASSERT_SVH

// Antecedent in one cycle implies consequent in the same cycle.
`define PFBV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define PFBV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pfbv_pkg.sv
// Shared constants, types and the palette table of the playfield beam video generator.
// Depends on nothing; every other file but the assertion macro header imports it.
`default_nettype none
package pfbv_pkg;

	localparam int unsigned IMAGE_WIDTH    = 160;
	localparam int unsigned IMAGE_HEIGHT   = 192;
	localparam int unsigned LINE_CLOCKS    = 228;
	localparam int unsigned FRAME_LINES    = 262;
	localparam int unsigned FIRST_VIS_COL  = 68;
	localparam int unsigned FIRST_VIS_LINE = 40;
	localparam int unsigned VSYNC_LINES    = 3;
	localparam int unsigned DRAW_COL_END   = 232;
	localparam int unsigned FIELD_CELLS    = 20;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned COL_W  = 8;
	localparam int unsigned LINE_W = 9;
	localparam int unsigned PAL_W  = 7;
	localparam int unsigned RGB_W  = 24;

	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	typedef enum logic [BYTE_W-1:0] {
		ADDR_VSYNC  = 8'h00,
		ADDR_WSYNC  = 8'h02,
		ADDR_COLUP0 = 8'h06,
		ADDR_COLUP1 = 8'h07,
		ADDR_COLUPF = 8'h08,
		ADDR_COLUBK = 8'h09,
		ADDR_CTRLPF = 8'h0a,
		ADDR_PF0    = 8'h0d,
		ADDR_PF1    = 8'h0e,
		ADDR_PF2    = 8'h0f
	} reg_addr_t;

	localparam int unsigned CTRL_MIRROR = 0;
	localparam int unsigned CTRL_SCORE  = 1;

	typedef struct packed {
		logic              mode;
		logic [BYTE_W-1:0] reg_addr;
		logic [BYTE_W-1:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [LINE_W-1:0] line;
		logic [BYTE_W-1:0] vsync_req;
		logic [BYTE_W-1:0] sync_wait;
		logic [BYTE_W-1:0] p0_colour;
		logic [BYTE_W-1:0] p1_colour;
		logic [BYTE_W-1:0] pf_colour;
		logic [BYTE_W-1:0] bg_colour;
		logic [BYTE_W-1:0] ctrl;
		logic [BYTE_W-1:0] pf_a;
		logic [BYTE_W-1:0] pf_b;
		logic [BYTE_W-1:0] pf_c;
	} regs_t;

	typedef struct packed {
		logic              pixel_valid;
		logic [BYTE_W-1:0] pixel_x;
		logic [BYTE_W-1:0] pixel_y;
		logic [PAL_W-1:0]  pal_idx;
		logic              in_vsync;
		logic              in_vblank;
		logic              in_hblank;
		logic              in_overscan;
		logic [BYTE_W-1:0] sync_hold;
	} stage_t;

	typedef struct packed {
		logic              pixel_valid;
		logic [BYTE_W-1:0] pixel_x;
		logic [BYTE_W-1:0] pixel_y;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic              in_vsync;
		logic              in_vblank;
		logic              in_hblank;
		logic              in_overscan;
		logic [BYTE_W-1:0] sync_hold;
	} pix_t;

	localparam logic [RGB_W-1:0] PALETTE [2**PAL_W] = '{
		24'h000000, 24'h404040, 24'h6c6c6c, 24'h909090,
		24'hb0b0b0, 24'hc8c8c8, 24'hdcdcdc, 24'hf4f4f4,
		24'h444400, 24'h646410, 24'h848424, 24'ha0a034,
		24'hb8b840, 24'hd0d050, 24'he8e85c, 24'hfcfc68,
		24'h702800, 24'h844414, 24'h985c28, 24'hac783c,
		24'hbc8c4c, 24'hcca05c, 24'hdcb468, 24'hecc878,
		24'h841800, 24'h983418, 24'hac5030, 24'hc06848,
		24'hd0805c, 24'he09470, 24'heca880, 24'hfcbc94,
		24'h880000, 24'h9c2020, 24'hb03c3c, 24'hc05858,
		24'hd07070, 24'he08888, 24'heca0a0, 24'hfcb4b4,
		24'h78005c, 24'h8c2074, 24'ha03c88, 24'hb0589c,
		24'hc070b0, 24'hd084c0, 24'hdc9cd0, 24'hecb0e0,
		24'h480078, 24'h602090, 24'h783ca4, 24'h8c58b8,
		24'ha070cc, 24'hb484dc, 24'hc49cec, 24'hd4b0fc,
		24'h140084, 24'h302098, 24'h4c3cac, 24'h6858c0,
		24'h7c70d0, 24'h9488e0, 24'ha8a0ec, 24'hbcb4fc,
		24'h000088, 24'h1c209c, 24'h3840b0, 24'h505cc0,
		24'h6874d0, 24'h7c8ce0, 24'h90a4ec, 24'ha4b8fc,
		24'h00187c, 24'h1c3890, 24'h3854a8, 24'h5070bc,
		24'h6888cc, 24'h7c9cdc, 24'h90b4ec, 24'ha4c8fc,
		24'h002c5c, 24'h1c4c78, 24'h386890, 24'h5084ac,
		24'h689cc0, 24'h7cb4d4, 24'h90cce8, 24'ha4e0fc,
		24'h003c2c, 24'h1c5c48, 24'h387c64, 24'h509c80,
		24'h68b494, 24'h7cd0ac, 24'h90e4c0, 24'ha4fcd4,
		24'h003c00, 24'h205c20, 24'h407c40, 24'h5c9c5c,
		24'h74b474, 24'h8cd08c, 24'ha4e4a4, 24'hb8fcb8,
		24'h143800, 24'h345c1c, 24'h507c38, 24'h6c9850,
		24'h84b468, 24'h9ccc7c, 24'hb4e490, 24'hc8fca4,
		24'h2c3000, 24'h4c501c, 24'h687034, 24'h848c4c,
		24'h9ca864, 24'hb4c078, 24'hccd488, 24'he0ec9c,
		24'h442800, 24'h644818, 24'h846830, 24'ha08444,
		24'hb89c58, 24'hd0b46c, 24'he8cc7c, 24'hfce08c
	};

endpackage
`default_nettype wire

FILE: hdl/pfbv_in_if.sv
// Command channel of the playfield beam video generator: valid/ready plus one tick or write.
// Depends on pfbv_pkg.
`default_nettype none
interface pfbv_in_if;
	import pfbv_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic [BYTE_W-1:0] reg_addr;
	logic [BYTE_W-1:0] write_data;

	modport source (output valid, output mode, output reg_addr, output write_data,
		input ready);
	modport sink (input valid, input mode, input reg_addr, input write_data,
		output ready);
endinterface
`default_nettype wire

FILE: hdl/pfbv_out_if.sv
// Pixel channel of the playfield beam video generator: valid/ready plus one result item.
// Depends on pfbv_pkg.
`default_nettype none
interface pfbv_out_if;
	import pfbv_pkg::*;

	logic              valid;
	logic              ready;
	logic              pixel_valid;
	logic [BYTE_W-1:0] pixel_x;
	logic [BYTE_W-1:0] pixel_y;
	logic [BYTE_W-1:0] red;
	logic [BYTE_W-1:0] green;
	logic [BYTE_W-1:0] blue;
	logic              in_vsync;
	logic              in_vblank;
	logic              in_hblank;
	logic              in_overscan;
	logic [BYTE_W-1:0] sync_hold;

	modport source (output valid, output pixel_valid, output pixel_x, output pixel_y,
		output red, output green, output blue, output in_vsync, output in_vblank,
		output in_hblank, output in_overscan, output sync_hold, input ready);
	modport sink (input valid, input pixel_valid, input pixel_x, input pixel_y,
		input red, input green, input blue, input in_vsync, input in_vblank,
		input in_hblank, input in_overscan, input sync_hold, output ready);
endinterface
`default_nettype wire

FILE: hdl/playfield_beam_video_generator.sv
// Playfield beam video generator. Every accepted command (a colour-clock tick or a register
// write) yields exactly one result, in order. One command is accepted per clock cycle as long
// as the pixel channel keeps taking results; a result passes a flag/colour-pick register and
// then a palette output register on its way to the pixel channel. Register writes and the
// beam counter take effect at the command transfer itself, so a tick right after a write
// already sees it. Back-pressure from the pixel channel reaches cmd.ready combinationally.
// Depends on pfbv_pkg, pfbv_in_if, pfbv_out_if, pfbv_regs, pfbv_stage and pfbv_out.
`default_nettype none
module playfield_beam_video_generator (
	input  wire logic clk,
	input  wire logic arst_n,
	pfbv_in_if.sink   cmd,
	pfbv_out_if.source pixel
);
	import pfbv_pkg::*;

	cmd_t       cmd_item;
	regs_t      regs;
	stage_t     stage;
	pix_t       pix;
	logic [7:0] sync_next;
	logic       stage_valid;
	logic       out_valid;
	logic       accept;
	logic       take;

	assign cmd_item.mode       = cmd.mode;
	assign cmd_item.reg_addr   = cmd.reg_addr;
	assign cmd_item.write_data = cmd.write_data;

	// The first stage empties whenever the output register is free or being read.
	assign take      = stage_valid && (!out_valid || pixel.ready);
	assign cmd.ready = !stage_valid || take;
	assign accept    = cmd.valid && cmd.ready;

	pfbv_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd_item),
		.regs      (regs),
		.sync_next (sync_next)
	);

	pfbv_stage u_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.take        (take),
		.cmd         (cmd_item),
		.regs        (regs),
		.sync_next   (sync_next),
		.stage_valid (stage_valid),
		.stage       (stage)
	);

	pfbv_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.out_ready (pixel.ready),
		.stage     (stage),
		.out_valid (out_valid),
		.pix       (pix)
	);

	assign pixel.valid       = out_valid;
	assign pixel.pixel_valid = pix.pixel_valid;
	assign pixel.pixel_x     = pix.pixel_x;
	assign pixel.pixel_y     = pix.pixel_y;
	assign pixel.red         = pix.red;
	assign pixel.green       = pix.green;
	assign pixel.blue        = pix.blue;
	assign pixel.in_vsync    = pix.in_vsync;
	assign pixel.in_vblank   = pix.in_vblank;
	assign pixel.in_hblank   = pix.in_hblank;
	assign pixel.in_overscan = pix.in_overscan;
	assign pixel.sync_hold   = pix.sync_hold;
endmodule
`default_nettype wire

FILE: hdl/pfbv_regs.sv
// Register file and beam position counter; writes set the registers and ticks advance the beam.
// Depends on pfbv_pkg.
`default_nettype none
module pfbv_regs (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire pfbv_pkg::cmd_t  cmd,
	output pfbv_pkg::regs_t      regs,
	output logic [7:0]           sync_next
);
	import pfbv_pkg::*;

	regs_t             regs_q;
	logic              vs_pend;
	logic [COL_W:0]    col_inc;
	logic [LINE_W:0]   line_inc;
	logic              wrap;
	logic [COL_W-1:0]  col_next;
	logic [LINE_W-1:0] line_next;

	// A pending vsync request restarts the beam at line 0 column 0 before the advance.
	always_comb begin
		vs_pend  = (regs_q.vsync_req != '0);
		col_inc  = (vs_pend ? '0 : {1'b0, regs_q.col}) + 1'b1;
		line_inc = (vs_pend ? '0 : {1'b0, regs_q.line}) + 1'b1;
		wrap     = (col_inc >= (COL_W+1)'(LINE_CLOCKS));
		col_next = wrap ? '0 : col_inc[COL_W-1:0];
		if (!wrap) begin
			line_next = vs_pend ? '0 : regs_q.line;
		end else if (line_inc >= (LINE_W+1)'(FRAME_LINES)) begin
			line_next = '0;
		end else begin
			line_next = line_inc[LINE_W-1:0];
		end
		if (cmd.mode == MODE_WRITE) begin
			sync_next = (cmd.reg_addr == ADDR_WSYNC) ? cmd.write_data : regs_q.sync_wait;
		end else begin
			sync_next = wrap ? '1 : regs_q.sync_wait;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{sync_wait: 8'hff, default: '0};
		end else if (accept) begin
			regs_q.sync_wait <= sync_next;
			if (cmd.mode == MODE_WRITE) begin
				case (cmd.reg_addr)
					ADDR_VSYNC:  regs_q.vsync_req <= cmd.write_data;
					ADDR_COLUP0: regs_q.p0_colour <= cmd.write_data;
					ADDR_COLUP1: regs_q.p1_colour <= cmd.write_data;
					ADDR_COLUPF: regs_q.pf_colour <= cmd.write_data;
					ADDR_COLUBK: regs_q.bg_colour <= cmd.write_data;
					ADDR_CTRLPF: regs_q.ctrl      <= cmd.write_data;
					ADDR_PF0:    regs_q.pf_a      <= cmd.write_data;
					ADDR_PF1:    regs_q.pf_b      <= cmd.write_data;
					ADDR_PF2:    regs_q.pf_c      <= cmd.write_data;
					default: ;
				endcase
			end else begin
				regs_q.col       <= col_next;
				regs_q.line      <= line_next;
				regs_q.vsync_req <= '0;
			end
		end
	end

	assign regs = regs_q;
endmodule
`default_nettype wire

FILE: hdl/pfbv_stage.sv
// First pipeline stage: beam flags, pixel position and playfield colour pick, registered.
// Depends on pfbv_pkg.
`default_nettype none
module pfbv_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic             take,
	input  wire pfbv_pkg::cmd_t   cmd,
	input  wire pfbv_pkg::regs_t  regs,
	input  wire logic [7:0]       sync_next,
	output logic                  stage_valid,
	output pfbv_pkg::stage_t      stage
);
	import pfbv_pkg::*;

	logic              valid_s1;
	stage_t            stage_s1;
	stage_t            calc;
	logic              vis_line;
	logic              draw;
	logic [COL_W-1:0]  x;
	logic [LINE_W-1:0] y_full;
	logic [5:0]        slot;
	logic [4:0]        idx;
	logic [FIELD_CELLS-1:0] pf_bits;
	logic [BYTE_W-1:0] colour;

	always_comb begin
		pf_bits[3:0]   = regs.pf_a[7:4];
		for (int k = 0; k < 8; k++) begin
			pf_bits[4+k] = regs.pf_b[7-k];
		end
		pf_bits[19:12] = regs.pf_c;

		x      = regs.col - COL_W'(FIRST_VIS_COL);
		y_full = regs.line - LINE_W'(FIRST_VIS_LINE);
		slot   = x[7:2];
		// The right half either repeats the 20 cells or reads them back to front.
		if (regs.ctrl[CTRL_MIRROR] && slot > 6'd19) begin
			idx = 5'(6'd39 - slot);
		end else if (slot >= 6'd20) begin
			idx = 5'(slot - 6'd20);
		end else begin
			idx = slot[4:0];
		end
		if (!pf_bits[idx]) begin
			colour = regs.bg_colour;
		end else if (regs.ctrl[CTRL_SCORE]) begin
			colour = (slot < 6'd20) ? regs.p0_colour : regs.p1_colour;
		end else begin
			colour = regs.pf_colour;
		end

		vis_line = (regs.line >= LINE_W'(FIRST_VIS_LINE))
			&& (regs.line < LINE_W'(FIRST_VIS_LINE + IMAGE_HEIGHT));
		draw = (regs.col >= COL_W'(FIRST_VIS_COL)) && (regs.col < COL_W'(DRAW_COL_END))
			&& (regs.line >= LINE_W'(FIRST_VIS_LINE));

		calc           = '0;
		calc.sync_hold = sync_next;
		if (cmd.mode == MODE_TICK) begin
			calc.in_vsync    = (regs.line < LINE_W'(VSYNC_LINES));
			calc.in_vblank   = (regs.line >= LINE_W'(VSYNC_LINES))
				&& (regs.line < LINE_W'(FIRST_VIS_LINE));
			calc.in_hblank   = vis_line && (regs.col < COL_W'(FIRST_VIS_COL));
			calc.in_overscan = (regs.line >= LINE_W'(FIRST_VIS_LINE + IMAGE_HEIGHT));
			if (draw && (x < COL_W'(IMAGE_WIDTH)) && (y_full < LINE_W'(IMAGE_HEIGHT))) begin
				calc.pixel_valid = 1'b1;
				calc.pixel_x     = x;
				calc.pixel_y     = y_full[BYTE_W-1:0];
				calc.pal_idx     = colour[BYTE_W-1:1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= calc;
		end
	end

	assign stage_valid = valid_s1;
	assign stage       = stage_s1;
endmodule
`default_nettype wire

FILE: hdl/pfbv_out.sv
// Second pipeline stage: palette lookup into the output register that drives the pixel channel.
// Depends on pfbv_pkg.
`default_nettype none
module pfbv_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic              out_ready,
	input  wire pfbv_pkg::stage_t  stage,
	output logic                   out_valid,
	output pfbv_pkg::pix_t         pix
);
	import pfbv_pkg::*;

	logic             valid_s2;
	pix_t             pix_s2;
	logic [RGB_W-1:0] rgb;

	assign rgb = stage.pixel_valid ? PALETTE[stage.pal_idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_s2.pixel_valid <= stage.pixel_valid;
			pix_s2.pixel_x     <= stage.pixel_x;
			pix_s2.pixel_y     <= stage.pixel_y;
			pix_s2.red         <= rgb[23:16];
			pix_s2.green       <= rgb[15:8];
			pix_s2.blue        <= rgb[7:0];
			pix_s2.in_vsync    <= stage.in_vsync;
			pix_s2.in_vblank   <= stage.in_vblank;
			pix_s2.in_hblank   <= stage.in_hblank;
			pix_s2.in_overscan <= stage.in_overscan;
			pix_s2.sync_hold   <= stage.sync_hold;
		end
	end

	assign out_valid = valid_s2;
	assign pix       = pix_s2;
endmodule
`default_nettype wire

FILE: hdl/pfbv_checker.sv
// Port-level checker of the playfield beam video generator and the bind that attaches it.
// Depends on pfbv_pkg and the assertion macro header.
`default_nettype none
`include "playfield_beam_video_generator_assert.svh"
module pfbv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cmd_valid,
	input wire logic       cmd_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       pixel_valid,
	input wire logic [7:0] pixel_x,
	input wire logic [7:0] pixel_y,
	input wire logic       in_vsync,
	input wire logic       in_vblank,
	input wire logic       in_hblank,
	input wire logic       in_overscan,
	input wire logic [7:0] sync_hold
);
	import pfbv_pkg::*;

	logic cmd_xfer;
	logic stalled;

	assign cmd_xfer = cmd_valid && cmd_ready;
	assign stalled  = out_valid && !out_ready;

	// A stalled result keeps its valid, its pixel flag, its position and its sync hold.
	`PFBV_ASSERT_NXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(sync_hold) && $stable(pixel_valid), "stalled result changed")

	// A visible pixel lies inside the image and outside every blanking interval.
	`PFBV_ASSERT_IMP(a_pix_inside, clk, arst_n, out_valid && pixel_valid, (pixel_x < 8'(IMAGE_WIDTH)) && (pixel_y < 8'(IMAGE_HEIGHT)) && !in_vsync && !in_vblank && !in_hblank && !in_overscan, "visible pixel out of image or in blanking")

	// At most one of the beam region flags is set at a time.
	`PFBV_ASSERT_IMP(a_flags_excl, clk, arst_n, out_valid, $countones({in_vsync, in_vblank, in_hblank, in_overscan}) <= 1, "beam region flags overlap")

	// A result only shows up after a command transfer that caused it.
	`PFBV_ASSERT_IMP(a_no_invent, clk, arst_n, $rose(out_valid), $past(cmd_xfer, 2), "result without a command")
endmodule

bind playfield_beam_video_generator pfbv_checker u_pfbv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.out_valid   (pixel.valid),
	.out_ready   (pixel.ready),
	.pixel_valid (pixel.pixel_valid),
	.pixel_x     (pixel.pixel_x),
	.pixel_y     (pixel.pixel_y),
	.in_vsync    (pixel.in_vsync),
	.in_vblank   (pixel.in_vblank),
	.in_hblank   (pixel.in_hblank),
	.in_overscan (pixel.in_overscan),
	.sync_hold   (pixel.sync_hold)
);
`default_nettype wire
